// ===== rtl/flash_command_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// Flash command sequencer assertion macros
// Shared concurrent assertion forms: clocked, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FLASH_COMMAND_SEQUENCER_ASSERT_SVH
`define FLASH_COMMAND_SEQUENCER_ASSERT_SVH

// Same-cycle implication
`define FCS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define FCS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/fcs_pkg.sv =====
// ----------------------------------------------------------------------------
// fcs_pkg
// Types, constants and unlock sequence tables of the flash command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package fcs_pkg;

   // History depth and derived widths
   localparam int SEQ_DEPTH = 6;
   localparam int SEQ_IDX_W = $clog2(SEQ_DEPTH);
   localparam int SEQ_CNT_W = $clog2(SEQ_DEPTH + 1);

   // Field widths
   localparam int OFFSET_W    = 22;
   localparam int BYTE_W      = 8;
   localparam int SECTOR_W    = 6;
   localparam int HIST_ADDR_W = 12;

   // Offset bit positions: 64 KiB sectors, 8 KiB boot blocks
   localparam int SECTOR_SHIFT = 16;
   localparam int BLOCK_SHIFT  = 13;

   // Lock register file
   localparam int LOCK_SMALL_W = 8;
   localparam int LOCK_LARGE_W = 63;
   localparam int LOCK_ENTRIES = LOCK_SMALL_W + LOCK_LARGE_W;
   localparam int ENTRY_W      = $clog2(LOCK_ENTRIES + 1);
   localparam logic [LOCK_SMALL_W-1:0] LOCK_SMALL_RESET = 8'hFF;
   localparam logic [LOCK_LARGE_W-1:0] LOCK_LARGE_RESET = 63'd2;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = LOCK_LARGE_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCK_SMALL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCK_LARGE = 2'd1;

   // Command bytes
   localparam logic [BYTE_W-1:0] STATUS_BYTE = 8'h80;
   localparam logic [BYTE_W-1:0] ABORT_BYTE  = 8'hF0;

   // Sector erase polling: last status read before returning to idle
   localparam logic [1:0] POLL_LAST = 2'd3;

   // Unlock sequences
   localparam int PAT_SLOTS        = 6;
   localparam int NUM_PATTERNS     = 4;
   localparam int PAT_PROGRAM      = 0;
   localparam int PAT_SECTOR_ERASE = 1;
   localparam int PAT_CHIP_ERASE   = 2;
   localparam int PAT_PROT         = 3;

   typedef enum logic {
      KIND_READ  = 1'b0,
      KIND_WRITE = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ACT_NONE         = 3'd0,
      ACT_ARRAY_READ   = 3'd1,
      ACT_STATUS_READ  = 3'd2,
      ACT_PROGRAM      = 3'd3,
      ACT_SECTOR_ERASE = 3'd4,
      ACT_CHIP_ERASE   = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_SERASE = 2'd1,
      MODE_CERASE = 2'd2,
      MODE_PROT   = 2'd3
   } mode_type;

   typedef struct packed {
      kind_type              kind;
      logic [OFFSET_W-1:0]   offset;
      logic [BYTE_W-1:0]     wdata;
   } req_type;

   typedef struct packed {
      action_type            action;
      logic [OFFSET_W-1:0]   target;
      logic [SECTOR_W-1:0]   sector;
      logic [BYTE_W-1:0]     rdata;
   } rsp_type;

   // Matcher verdict for one write
   typedef struct packed {
      logic [NUM_PATTERNS-1:0] hit;     // first fully matched sequence, one-hot
      logic                    keep;    // history is still a prefix of a sequence
      logic [SEQ_CNT_W-1:0]    count;   // history length including this write
      logic [SEQ_IDX_W-1:0]    pos;     // slot this write goes to
   } match_type;

   typedef struct packed {
      logic [SEQ_CNT_W-1:0]                    len;
      logic [0:PAT_SLOTS-1][HIST_ADDR_W-1:0]   addr;
      logic [0:PAT_SLOTS-1][HIST_ADDR_W-1:0]   amask;
      logic [0:PAT_SLOTS-1][BYTE_W-1:0]        val;
      logic [0:PAT_SLOTS-1][BYTE_W-1:0]        vmask;
   } pattern_type;

   localparam pattern_type PATTERNS [NUM_PATTERNS] = '{
      // program: last write is the data, matches anything
      '{len:   SEQ_CNT_W'(4),
        addr:  '{12'hAAA, 12'h555, 12'hAAA, 12'h000, 12'h000, 12'h000},
        amask: '{12'hFFF, 12'hFFF, 12'hFFF, 12'h000, 12'h000, 12'h000},
        val:   '{8'hAA, 8'h55, 8'hA0, 8'h00, 8'h00, 8'h00},
        vmask: '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00}},
      // sector erase: last address is the sector
      '{len:   SEQ_CNT_W'(6),
        addr:  '{12'hAAA, 12'h555, 12'hAAA, 12'hAAA, 12'h555, 12'h000},
        amask: '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'h000},
        val:   '{8'hAA, 8'h55, 8'h80, 8'hAA, 8'h55, 8'h30},
        vmask: '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}},
      // chip erase
      '{len:   SEQ_CNT_W'(6),
        addr:  '{12'hAAA, 12'h555, 12'hAAA, 12'hAAA, 12'h555, 12'hAAA},
        amask: '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF},
        val:   '{8'hAA, 8'h55, 8'h80, 8'hAA, 8'h55, 8'h10},
        vmask: '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}},
      // protection read entry
      '{len:   SEQ_CNT_W'(3),
        addr:  '{12'hAAA, 12'h555, 12'hAAA, 12'h000, 12'h000, 12'h000},
        amask: '{12'hFFF, 12'hFFF, 12'hFFF, 12'h000, 12'h000, 12'h000},
        val:   '{8'hAA, 8'h55, 8'h90, 8'h00, 8'h00, 8'h00},
        vmask: '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00}}
   };

endpackage

`default_nettype wire

// ===== rtl/fcs_match.sv =====
// ----------------------------------------------------------------------------
// fcs_match
// Parallel compare of the write history plus the incoming write against all
// unlock sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module fcs_match (
   input  logic [fcs_pkg::HIST_ADDR_W-1:0] hist_addr  [fcs_pkg::SEQ_DEPTH],
   input  logic [fcs_pkg::BYTE_W-1:0]      hist_value [fcs_pkg::SEQ_DEPTH],
   input  logic [fcs_pkg::SEQ_CNT_W-1:0]   seq_count,
   input  logic [fcs_pkg::HIST_ADDR_W-1:0] new_addr,
   input  logic [fcs_pkg::BYTE_W-1:0]      new_value,
   output fcs_pkg::match_type              result
);
   import fcs_pkg::*;

   logic [SEQ_CNT_W-1:0]                       base;
   logic [SEQ_CNT_W-1:0]                       count_new;
   logic [SEQ_IDX_W-1:0]                       pos;
   logic [NUM_PATTERNS-1:0][PAT_SLOTS-1:0]     slot_ok;
   logic [NUM_PATTERNS-1:0]                    full;
   logic [NUM_PATTERNS-1:0]                    partial;
   logic [NUM_PATTERNS-1:0]                    hit;

   // Place the new write: restart the history if it is ever full
   always_comb begin
      base      = (seq_count >= SEQ_CNT_W'(SEQ_DEPTH)) ? '0 : seq_count;
      pos       = base[SEQ_IDX_W-1:0];
      count_new = base + SEQ_CNT_W'(1);
   end

   // Compare every slot against every sequence
   always_comb begin
      logic [HIST_ADDR_W-1:0] a;
      logic [BYTE_W-1:0]      v;
      for (int k = 0; k < NUM_PATTERNS; k++) begin
         for (int i = 0; i < PAT_SLOTS; i++) begin
            if (SEQ_IDX_W'(i) == pos) begin
               a = new_addr;
               v = new_value;
            end else begin
               a = hist_addr[i];
               v = hist_value[i];
            end
            slot_ok[k][i] = ((a & PATTERNS[k].amask[i]) == PATTERNS[k].addr[i]) &&
                            ((v & PATTERNS[k].vmask[i]) == PATTERNS[k].val[i]);
         end
      end
   end

   // Full match over the sequence length, prefix match over the history
   always_comb begin
      logic full_ok;
      logic part_ok;
      for (int k = 0; k < NUM_PATTERNS; k++) begin
         full_ok = 1'b1;
         part_ok = 1'b1;
         for (int i = 0; i < PAT_SLOTS; i++) begin
            if ((SEQ_CNT_W'(i) < PATTERNS[k].len) && !slot_ok[k][i]) begin
               full_ok = 1'b0;
            end
            if ((SEQ_CNT_W'(i) < count_new) && !slot_ok[k][i]) begin
               part_ok = 1'b0;
            end
         end
         full[k]    = full_ok && (count_new >= PATTERNS[k].len);
         partial[k] = part_ok && (count_new <= PATTERNS[k].len);
      end
   end

   // Pick the first full match in table order
   always_comb begin
      hit = '0;
      for (int k = 0; k < NUM_PATTERNS; k++) begin
         if (full[k] && (hit == '0)) begin
            hit[k] = 1'b1;
         end
      end
      result.hit   = hit;
      result.keep  = !(|full) && (|partial);
      result.count = count_new;
      result.pos   = pos;
   end

endmodule

`default_nettype wire

// ===== rtl/fcs_lock.sv =====
// ----------------------------------------------------------------------------
// fcs_lock
// Sector lock registers with their write port, and the two lock lookups:
// protection read entry and sector erase target.
// ----------------------------------------------------------------------------
`default_nettype none

module fcs_lock (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fcs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fcs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [fcs_pkg::OFFSET_W-1:0]     offset,
   output logic                             prot_locked,
   output logic                             sector_locked
);
   import fcs_pkg::*;

   logic [LOCK_SMALL_W-1:0] lock_small_ff, lock_small_in;
   logic [LOCK_LARGE_W-1:0] lock_large_ff, lock_large_in;
   logic [LOCK_ENTRIES-1:0] lock_all;
   logic [SECTOR_W-1:0]     sector;
   logic [ENTRY_W-1:0]      entry;

   assign csr_ready = 1'b1;

   // Decode register writes; unknown indexes are dropped
   always_comb begin
      lock_small_in = lock_small_ff;
      lock_large_in = lock_large_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LOCK_SMALL: lock_small_in = csr_wdata[LOCK_SMALL_W-1:0];
            CSR_LOCK_LARGE: lock_large_in = csr_wdata[LOCK_LARGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_small_ff <= LOCK_SMALL_RESET;
         lock_large_ff <= LOCK_LARGE_RESET;
      end else begin
         lock_small_ff <= lock_small_in;
         lock_large_ff <= lock_large_in;
      end
   end

   // Look up lock bits; entries past the table read unlocked
   always_comb begin
      lock_all = {lock_large_ff, lock_small_ff};
      sector   = offset[SECTOR_SHIFT +: SECTOR_W];
      if (sector == '0) begin
         entry = ENTRY_W'(offset[BLOCK_SHIFT +: (SECTOR_SHIFT - BLOCK_SHIFT)]);
      end else begin
         entry = ENTRY_W'(sector) + ENTRY_W'(LOCK_SMALL_W);
      end
      prot_locked   = (entry < ENTRY_W'(LOCK_ENTRIES)) ? lock_all[entry] : 1'b0;
      sector_locked = lock_all[ENTRY_W'(sector)];
   end

endmodule

`default_nettype wire

// ===== rtl/flash_command_sequencer.sv =====
// Path: an access passes from the input register through the command decode
//   into the result register, which presents its result.
// Throughput: one access per cycle without rsp_stall; the six-entry history
//   compare and command decode sit in one stage between the two registers.
// Reset (synchronous): mode idle, history and poll counters cleared, lock
//   registers at 0xFF and 0x2; both registers empty.
`default_nettype none

`include "flash_command_sequencer_assert.svh"

module flash_command_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  fcs_pkg::req_type                 req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output fcs_pkg::rsp_type                 rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fcs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fcs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import fcs_pkg::*;

   // Pipeline registers
   logic                    in_valid_ff, in_valid_in;
   req_type                 in_data_ff;
   logic                    out_valid_ff, out_valid_in;
   rsp_type                 out_data_ff;
   logic                    advance;

   // Command state
   mode_type                mode_ff, mode_in;
   logic [SEQ_CNT_W-1:0]    seq_count_ff, seq_count_in;
   logic [1:0]              poll_count_ff, poll_count_in;
   logic [1:0]              poll_next;
   logic [HIST_ADDR_W-1:0]  hist_addr_ff  [SEQ_DEPTH];
   logic [BYTE_W-1:0]       hist_value_ff [SEQ_DEPTH];
   logic                    hist_we;
   logic                    abort;

   rsp_type                 calc;
   match_type               verdict;
   logic                    prot_locked;
   logic                    sector_locked;

   // Move items: input stage drains when the result register is free
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   always_comb begin
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_payload;
      end
      if (advance) begin
         out_data_ff <= calc;
      end
   end

   fcs_match u_match (
      .hist_addr  (hist_addr_ff),
      .hist_value (hist_value_ff),
      .seq_count  (seq_count_ff),
      .new_addr   (in_data_ff.offset[HIST_ADDR_W-1:0]),
      .new_value  (in_data_ff.wdata),
      .result     (verdict)
   );

   fcs_lock u_lock (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .offset        (in_data_ff.offset),
      .prot_locked   (prot_locked),
      .sector_locked (sector_locked)
   );

   // Decode the access against the current mode and the matcher verdict
   always_comb begin
      calc          = '0;
      calc.action   = ACT_NONE;
      mode_in       = mode_ff;
      seq_count_in  = seq_count_ff;
      poll_count_in = poll_count_ff;
      poll_next     = poll_count_ff + 2'd1;
      hist_we       = 1'b0;
      abort         = (in_data_ff.kind == KIND_WRITE) && (mode_ff != MODE_IDLE) &&
                      (in_data_ff.wdata == ABORT_BYTE);
      if (advance) begin
         if (in_data_ff.kind == KIND_READ) begin
            unique case (mode_ff)
               MODE_IDLE: begin
                  calc.action = ACT_ARRAY_READ;
                  calc.target = in_data_ff.offset;
               end
               MODE_SERASE: begin
                  calc.action = ACT_STATUS_READ;
                  calc.rdata  = STATUS_BYTE;
                  if (poll_next == POLL_LAST) begin
                     poll_count_in = '0;
                     mode_in       = MODE_IDLE;
                  end else begin
                     poll_count_in = poll_next;
                  end
               end
               MODE_CERASE: begin
                  calc.action = ACT_STATUS_READ;
                  calc.rdata  = STATUS_BYTE;
                  mode_in     = MODE_IDLE;
               end
               MODE_PROT: begin
                  calc.action = ACT_STATUS_READ;
                  calc.rdata  = BYTE_W'(prot_locked);
               end
               default: ;
            endcase
         end else if (abort) begin
            mode_in      = MODE_IDLE;
            seq_count_in = '0;
         end else begin
            hist_we      = 1'b1;
            seq_count_in = verdict.keep ? verdict.count : '0;
            if (verdict.hit[PAT_PROGRAM]) begin
               calc.action = ACT_PROGRAM;
               calc.target = in_data_ff.offset;
               calc.rdata  = in_data_ff.wdata;
            end else if (verdict.hit[PAT_SECTOR_ERASE]) begin
               mode_in = MODE_SERASE;
               if (!sector_locked) begin
                  calc.action = ACT_SECTOR_ERASE;
                  calc.sector = in_data_ff.offset[SECTOR_SHIFT +: SECTOR_W];
               end
            end else if (verdict.hit[PAT_CHIP_ERASE]) begin
               mode_in     = MODE_CERASE;
               calc.action = ACT_CHIP_ERASE;
            end else if (verdict.hit[PAT_PROT]) begin
               mode_in = MODE_PROT;
            end
         end
      end
   end

   // Hold command state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         seq_count_ff  <= '0;
         poll_count_ff <= '0;
      end else begin
         mode_ff       <= mode_in;
         seq_count_ff  <= seq_count_in;
         poll_count_ff <= poll_count_in;
      end
   end

   // Append the write to the history
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_addr_ff[verdict.pos]  <= in_data_ff.offset[HIST_ADDR_W-1:0];
         hist_value_ff[verdict.pos] <= in_data_ff.wdata;
      end
   end

   `FCS_ASSERT_IMP(a_seq_count_bound, clock, reset, 1'b1, seq_count_ff < SEQ_CNT_W'(SEQ_DEPTH), "history count out of range")
   `FCS_ASSERT_IMP(a_poll_bound, clock, reset, 1'b1, poll_count_ff != POLL_LAST, "poll count reached its wrap value")
   `FCS_ASSERT_IMP(a_stall_needs_item, clock, reset, req_stall, in_valid_ff, "input stalled with an empty stage")
   `FCS_ASSERT_NXT(a_erase_sets_mode, clock, reset, advance && (calc.action == ACT_SECTOR_ERASE || calc.action == ACT_CHIP_ERASE), mode_ff == MODE_SERASE || mode_ff == MODE_CERASE, "erase issued without erase mode")
   `FCS_ASSERT_NXT(a_abort_clears, clock, reset, advance && abort, mode_ff == MODE_IDLE && seq_count_ff == '0, "abort left a command active")

endmodule

`default_nettype wire
